FILE: rtl/fcte_pkg.sv
package fcte_pkg;

  localparam int DefEntries    = 1024;
  localparam int DefQueueDepth = 2;

  localparam logic [15:0] MarkEnd  = 16'hFFFF;
  localparam logic [15:0] MarkBad  = 16'hFFFE;
  localparam logic [15:0] MarkFree = 16'hFFFD;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StUnmounted = 3'd1;
  localparam logic [2:0] StInvalid   = 3'd2;
  localparam logic [2:0] StNoneFree  = 3'd3;
  localparam logic [2:0] StNoneDone  = 3'd4;

  localparam logic [1:0] KindFind  = 2'd0;
  localparam logic [1:0] KindNext  = 2'd1;
  localparam logic [1:0] KindFree  = 2'd2;
  localparam logic [1:0] KindWrite = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] block_num;
    logic [15:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [15:0] block_out;
    logic [2:0]  status;
  } res_t;

  // Work left for the back end once a request has been checked.
  typedef enum logic [2:0] {
    OP_DONE,
    OP_FIND,
    OP_NEXT,
    OP_FREE,
    OP_WRITE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] rel;
    logic [15:0] value;
    res_t        res;
  } cmd_t;

  function automatic logic is_marker(input logic [15:0] v);
    return (v == MarkEnd) || (v == MarkBad) || (v == MarkFree);
  endfunction

endpackage

FILE: rtl/fcte_front.sv
module fcte_front #(
  parameter int ENTRIES = fcte_pkg::DefEntries
) (
  input  logic             start_i,
  output logic             busy_o,
  input  fcte_pkg::req_t   req_i,
  input  logic [15:0]      data_start_i,
  input  logic             mounted_i,
  input  logic             init_done_i,
  input  logic             full_i,
  output logic             push_o,
  output fcte_pkg::cmd_t   cmd_o
);

  localparam logic [16:0] EntriesW = 17'(ENTRIES);

  logic [15:0] rel;
  logic        below;
  logic        in_range;

  assign rel      = req_i.block_num - data_start_i;
  assign below    = req_i.block_num < data_start_i;
  assign in_range = !below && ({1'b0, rel} < EntriesW);

  assign busy_o = !init_done_i || full_i;
  assign push_o = start_i && !busy_o;

  always_comb begin
    cmd_o               = '0;
    cmd_o.op            = fcte_pkg::OP_DONE;
    cmd_o.rel           = rel;
    cmd_o.value         = req_i.entry_value;
    cmd_o.res.block_out = '0;
    cmd_o.res.status    = fcte_pkg::StOk;
    case (req_i.kind)
      fcte_pkg::KindFind: begin
        cmd_o.op = fcte_pkg::OP_FIND;
      end
      fcte_pkg::KindNext: begin
        if (!mounted_i) begin
          cmd_o.res.block_out = fcte_pkg::MarkBad;
          cmd_o.res.status    = fcte_pkg::StUnmounted;
        end else if (!in_range) begin
          cmd_o.res.block_out = fcte_pkg::MarkBad;
          cmd_o.res.status    = fcte_pkg::StInvalid;
        end else begin
          cmd_o.op = fcte_pkg::OP_NEXT;
        end
      end
      fcte_pkg::KindFree: begin
        // A start block that is itself a marker frees nothing and succeeds.
        if (!mounted_i) begin
          cmd_o.res.status = fcte_pkg::StUnmounted;
        end else if (below) begin
          cmd_o.res.status = fcte_pkg::StNoneDone;
        end else if (fcte_pkg::is_marker(req_i.block_num)) begin
          cmd_o.res.status = fcte_pkg::StOk;
        end else if (!in_range) begin
          cmd_o.res.status = fcte_pkg::StInvalid;
        end else begin
          cmd_o.op = fcte_pkg::OP_FREE;
        end
      end
      fcte_pkg::KindWrite: begin
        if (!mounted_i) begin
          cmd_o.res.status = fcte_pkg::StUnmounted;
        end else if (!in_range) begin
          cmd_o.res.status = fcte_pkg::StInvalid;
        end else begin
          cmd_o.op = fcte_pkg::OP_WRITE;
        end
      end
      default: begin
        cmd_o.op = fcte_pkg::OP_DONE;
      end
    endcase
  end

endmodule

FILE: rtl/fcte_fifo.sv
module fcte_fifo #(
  parameter int DEPTH = fcte_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcte_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output fcte_pkg::cmd_t cmd_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  fcte_pkg::cmd_t slot_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/fcte_back.sv
module fcte_back #(
  parameter int ENTRIES = fcte_pkg::DefEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    data_start_i,
  input  logic           cmd_valid_i,
  input  fcte_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           init_done_o,
  output logic           res_valid_o,
  output fcte_pkg::res_t res_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LastIdx  = IW'(ENTRIES - 1);
  localparam logic [16:0]   EntriesW = 17'(ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_NEXT  = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;

  logic [15:0]    mem_q [ENTRIES];
  logic [15:0]    rd_q;
  logic [2:0]     state_q, state_d;
  logic [IW-1:0]  ptr_q, ptr_d;
  logic           res_valid_q, res_valid_d;
  fcte_pkg::res_t res_q, res_d;

  logic           we;
  logic [IW-1:0]  wa;
  logic [15:0]    wd;
  logic [IW-1:0]  ra;
  logic [15:0]    nb;

  // Absolute block that a stored link points to.
  assign nb = data_start_i + rd_q;

  assign init_done_o = (state_q != S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    wa          = ptr_q;
    wd          = fcte_pkg::MarkFree;
    ra          = ptr_q;
    pop_o       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LastIdx) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            fcte_pkg::OP_WRITE: begin
              we          = 1'b1;
              wa          = cmd_i.rel[IW-1:0];
              wd          = cmd_i.value;
              res_valid_d = 1'b1;
              res_d       = '{block_out: '0, status: fcte_pkg::StOk};
            end
            fcte_pkg::OP_NEXT: begin
              ra      = cmd_i.rel[IW-1:0];
              ptr_d   = cmd_i.rel[IW-1:0];
              state_d = S_NEXT;
            end
            fcte_pkg::OP_FIND: begin
              ra      = '0;
              ptr_d   = '0;
              state_d = S_FIND;
            end
            fcte_pkg::OP_FREE: begin
              ra      = cmd_i.rel[IW-1:0];
              ptr_d   = cmd_i.rel[IW-1:0];
              state_d = S_FREE;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = cmd_i.res;
            end
          endcase
        end
      end
      S_NEXT: begin
        res_valid_d     = 1'b1;
        res_d.status    = fcte_pkg::StOk;
        res_d.block_out = fcte_pkg::is_marker(rd_q) ? rd_q : nb;
        state_d         = S_IDLE;
      end
      S_FIND: begin
        if (rd_q == fcte_pkg::MarkFree) begin
          res_valid_d = 1'b1;
          res_d       = '{block_out: data_start_i + 16'(ptr_q), status: fcte_pkg::StOk};
          state_d     = S_IDLE;
        end else if (ptr_q == LastIdx) begin
          res_valid_d = 1'b1;
          res_d       = '{block_out: fcte_pkg::MarkEnd, status: fcte_pkg::StNoneFree};
          state_d     = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
          ra    = ptr_q + 1'b1;
        end
      end
      S_FREE: begin
        // Free the entry just read and, if the chain goes on, fetch the next one in the same cycle.
        we = 1'b1;
        if (fcte_pkg::is_marker(rd_q) || fcte_pkg::is_marker(nb)) begin
          res_valid_d = 1'b1;
          res_d       = '{block_out: '0, status: fcte_pkg::StOk};
          state_d     = S_IDLE;
        end else if ((nb < data_start_i) || ({1'b0, rd_q} >= EntriesW)) begin
          res_valid_d = 1'b1;
          res_d       = '{block_out: '0, status: fcte_pkg::StInvalid};
          state_d     = S_IDLE;
        end else if (rd_q[IW-1:0] == ptr_q) begin
          // A link to itself would read the entry before this write lands;
          // it is free now, so the walk is over.
          res_valid_d = 1'b1;
          res_d       = '{block_out: '0, status: fcte_pkg::StOk};
          state_d     = S_IDLE;
        end else begin
          ptr_d = rd_q[IW-1:0];
          ra    = rd_q[IW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

endmodule

FILE: rtl/fat_chain_table_engine.sv
// A start reaches the result strobe through the request queue and the result register;
// next-link adds a table read, find-free reads entries until a free one or the last one,
// and free-chain reads along the chain. The back end takes one request at a time.
// A two-entry request queue lets start be taken while the back end is still working.
// After reset a clearing pass marks every entry free, one after another; busy is high.
// Results are strobed for one cycle and the receiver cannot stall them.
module fat_chain_table_engine #(
  parameter int ENTRIES     = fcte_pkg::DefEntries,
  parameter int QUEUE_DEPTH = fcte_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fcte_pkg::req_t req_i,
  output logic           res_valid_o,
  output fcte_pkg::res_t res_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [15:0]    data_start_q;
  logic           mounted_q;
  logic           cfg_we;
  logic           init_done;
  logic           full;
  logic           push;
  logic           pop;
  logic           cmd_valid;
  fcte_pkg::cmd_t push_cmd;
  fcte_pkg::cmd_t head_cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {31'b0, mounted_q} : {16'b0, data_start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
      mounted_q    <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        mounted_q <= pwdata[0];
      end else begin
        data_start_q <= pwdata[15:0];
      end
    end
  end

  fcte_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .start_i      (start),
    .busy_o       (busy),
    .req_i        (req_i),
    .data_start_i (data_start_q),
    .mounted_i    (mounted_q),
    .init_done_i  (init_done),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  fcte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .full_o  (full),
    .cmd_o   (head_cmd)
  );

  fcte_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_start_i (data_start_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .init_done_o  (init_done),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule
